// ===== design/ipv4hfe_pkg.sv =====
//------------------------------------------------------------------------------
// ipv4hfe_pkg
// Types and constants shared by the IPv4 header field extractor.
//------------------------------------------------------------------------------
`default_nettype none

package ipv4hfe_pkg;

	localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_ICMP = 8'd1;
	localparam logic [7:0]  PROTO_TCP  = 8'd6;
	localparam logic [7:0]  PROTO_UDP  = 8'd17;

	localparam int OFFSET_W = 6;
	localparam int LEN_W    = OFFSET_W + 1;

	localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

	localparam logic [OFFSET_W-1:0] POS_ETYPE_HI = 6'd12;
	localparam logic [OFFSET_W-1:0] POS_ETYPE_LO = 6'd13;
	localparam logic [OFFSET_W-1:0] POS_PROTO    = 6'd23;
	localparam logic [OFFSET_W-1:0] POS_SRC_LO   = 6'd26;
	localparam logic [OFFSET_W-1:0] POS_SRC_HI   = 6'd29;
	localparam logic [OFFSET_W-1:0] POS_DST_LO   = 6'd30;
	localparam logic [OFFSET_W-1:0] POS_DST_HI   = 6'd33;
	localparam logic [OFFSET_W-1:0] POS_L4_LO    = 6'd34;
	localparam logic [OFFSET_W-1:0] POS_L4_HI    = 6'd37;
	localparam logic [OFFSET_W-1:0] POS_TCP_FLAG = 6'd47;

	localparam logic [LEN_W-1:0] MIN_ETH_LEN  = 7'd14;
	localparam logic [LEN_W-1:0] MIN_IP_LEN   = 7'd34;
	localparam logic [LEN_W-1:0] MIN_ICMP_LEN = 7'd42;
	localparam logic [LEN_W-1:0] MIN_UDP_LEN  = 7'd42;
	localparam logic [LEN_W-1:0] MIN_TCP_LEN  = 7'd54;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        store_full;
		logic [63:0] time_ns;
	} in_item_t;

	typedef struct packed {
		logic        verdict;
		logic        record_valid;
		logic [63:0] arrival_time;
		logic [7:0]  ip_protocol;
		logic [31:0] source_address;
		logic [31:0] dest_address;
		logic [15:0] source_port;
		logic [15:0] dest_port;
		logic [7:0]  icmp_kind;
		logic [7:0]  icmp_subcode;
		logic [7:0]  tcp_flag_bits;
	} out_item_t;

	typedef struct packed {
		logic [LEN_W-1:0] frame_len;
		logic             no_space;
		logic [63:0]      frame_time;
		logic [15:0]      ether_kind;
		logic [7:0]       proto;
		logic [31:0]      src_addr;
		logic [31:0]      dst_addr;
		logic [31:0]      l4_word;
		logic [7:0]       tcp_flags;
	} frame_sum_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

`default_nettype wire

// ===== design/ipv4hfe_front.sv =====
//------------------------------------------------------------------------------
// ipv4hfe_front
// Byte parser: tracks the frame offset, captures header fields and hands a
// frame summary to the queue on the last byte.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4hfe_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      take,
	input  ipv4hfe_pkg::in_item_t    frame_byte,
	output logic                     sum_push,
	output ipv4hfe_pkg::frame_sum_t  sum
);
	import ipv4hfe_pkg::*;

	logic [OFFSET_W-1:0] offset_q;
	logic                no_space_q;
	logic [63:0]         time_q;
	logic [15:0]         ether_q;
	logic [7:0]          proto_q;
	logic [31:0]         src_q;
	logic [31:0]         dst_q;
	logic [31:0]         l4_q;
	logic [7:0]          flags_q;

	logic                first;
	logic                no_space_d;
	logic [63:0]         time_d;
	logic [15:0]         ether_d;
	logic [7:0]          proto_d;
	logic [31:0]         src_d;
	logic [31:0]         dst_d;
	logic [31:0]         l4_d;
	logic [7:0]          flags_d;
	logic [7:0]          b;

	assign first = (offset_q == '0);
	assign b     = frame_byte.data_byte;

	always_comb begin
		no_space_d = first ? frame_byte.store_full : no_space_q;
		time_d     = first ? frame_byte.time_ns : time_q;
		ether_d    = first ? '0 : ether_q;
		proto_d    = first ? '0 : proto_q;
		src_d      = first ? '0 : src_q;
		dst_d      = first ? '0 : dst_q;
		l4_d       = first ? '0 : l4_q;
		flags_d    = first ? '0 : flags_q;
		priority if (offset_q == POS_ETYPE_HI || offset_q == POS_ETYPE_LO) begin
			ether_d = {ether_d[7:0], b};
		end else if (offset_q == POS_PROTO) begin
			proto_d = b;
		end else if (offset_q >= POS_SRC_LO && offset_q <= POS_SRC_HI) begin
			src_d = {src_d[23:0], b};
		end else if (offset_q >= POS_DST_LO && offset_q <= POS_DST_HI) begin
			dst_d = {dst_d[23:0], b};
		end else if (offset_q >= POS_L4_LO && offset_q <= POS_L4_HI) begin
			l4_d = {l4_d[23:0], b};
		end else if (offset_q == POS_TCP_FLAG) begin
			flags_d = b;
		end else begin
			flags_d = flags_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else if (take) begin
			if (frame_byte.last_byte) begin
				offset_q <= '0;
			end else if (offset_q != OFFSET_MAX) begin
				offset_q <= offset_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			no_space_q <= no_space_d;
			time_q     <= time_d;
			ether_q    <= ether_d;
			proto_q    <= proto_d;
			src_q      <= src_d;
			dst_q      <= dst_d;
			l4_q       <= l4_d;
			flags_q    <= flags_d;
		end
	end

	assign sum_push       = take && frame_byte.last_byte;
	assign sum.frame_len  = {1'b0, offset_q} + LEN_W'(1);
	assign sum.no_space   = no_space_d;
	assign sum.frame_time = time_d;
	assign sum.ether_kind = ether_d;
	assign sum.proto      = proto_d;
	assign sum.src_addr   = src_d;
	assign sum.dst_addr   = dst_d;
	assign sum.l4_word    = l4_d;
	assign sum.tcp_flags  = flags_d;

endmodule

`default_nettype wire

// ===== design/ipv4hfe_queue.sv =====
//------------------------------------------------------------------------------
// ipv4hfe_queue
// Short queue of frame summaries between the parser and the classifier.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4hfe_queue (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           wr,
	input  ipv4hfe_pkg::frame_sum_t       wr_data,
	input  wire                           rd,
	output ipv4hfe_pkg::frame_sum_t       rd_data,
	output ipv4hfe_pkg::queue_status_t    status
);
	import ipv4hfe_pkg::*;

	localparam logic [QPTR_W-1:0] LAST_SLOT = QPTR_W'(QUEUE_DEPTH - 1);

	frame_sum_t          slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_wr;
	logic                do_rd;

	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_wr        = wr && !status.full;
	assign do_rd        = rd && !status.empty;
	assign rd_data      = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

`default_nettype wire

// ===== design/ipv4hfe_back.sv =====
//------------------------------------------------------------------------------
// ipv4hfe_back
// Classifier: turns a frame summary into a verdict and record, held in the
// output register until taken.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4hfe_back (
	input  wire                        clk,
	input  wire                        arst_n,
	input  ipv4hfe_pkg::frame_sum_t    head,
	input  wire                        head_valid,
	output logic                       head_take,
	output logic                       empty,
	input  wire                        pop,
	output ipv4hfe_pkg::out_item_t     result
);
	import ipv4hfe_pkg::*;

	logic      valid_q;
	out_item_t result_q;
	out_item_t res_d;
	logic      is_icmp;
	logic      is_tcp;
	logic      is_udp;
	logic      drop;
	logic      rec;

	assign is_icmp = (head.proto == PROTO_ICMP);
	assign is_tcp  = (head.proto == PROTO_TCP);
	assign is_udp  = (head.proto == PROTO_UDP);

	always_comb begin
		drop = 1'b0;
		rec  = 1'b0;
		priority if (head.no_space) begin
			drop = 1'b1;
		end else if (head.frame_len < MIN_ETH_LEN || head.ether_kind != ETYPE_IPV4) begin
			drop = 1'b0;
		end else if (head.frame_len < MIN_IP_LEN) begin
			drop = 1'b1;
		end else if ((is_icmp && head.frame_len < MIN_ICMP_LEN)
				|| (is_udp && head.frame_len < MIN_UDP_LEN)) begin
			drop = 1'b1;
		end else if (is_tcp && head.frame_len < MIN_TCP_LEN) begin
			drop = 1'b1;
		end else begin
			rec = 1'b1;
		end
	end

	always_comb begin
		res_d         = '0;
		res_d.verdict = drop;
		if (rec) begin
			res_d.record_valid   = 1'b1;
			res_d.arrival_time   = head.frame_time;
			res_d.ip_protocol    = head.proto;
			res_d.source_address = head.src_addr;
			res_d.dest_address   = head.dst_addr;
			if (is_tcp || is_udp) begin
				res_d.source_port = head.l4_word[31:16];
				res_d.dest_port   = head.l4_word[15:0];
			end
			if (is_icmp) begin
				res_d.icmp_kind    = head.l4_word[31:24];
				res_d.icmp_subcode = head.l4_word[23:16];
			end
			if (is_tcp) begin
				res_d.tcp_flag_bits = {head.tcp_flags[0], head.tcp_flags[1],
					head.tcp_flags[2], head.tcp_flags[3], head.tcp_flags[4],
					head.tcp_flags[5], 2'b00};
			end
		end
	end

	assign head_take = head_valid && (!valid_q || pop);
	assign empty     = !valid_q;
	assign result    = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (head_take) begin
			valid_q <= 1'b1;
		end else if (pop) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (head_take) begin
			result_q <= res_d;
		end
	end

endmodule

`default_nettype wire

// ===== design/ipv4_header_field_extractor.sv =====
//------------------------------------------------------------------------------
// ipv4_header_field_extractor
// Parses Ethernet/IPv4 frames byte by byte and gives one verdict and record
// per frame.
//------------------------------------------------------------------------------
// Usage:
//   Input channel: drive frame_byte and raise push; a byte is taken on a
//   clock edge with push high and full low. One byte per cycle is sustained while full is low.
//   The byte flagged last_byte closes the frame; store_full and time_ns are
//   sampled on the first byte of each frame.
//   Result channel: while empty is low, result holds the oldest verdict and
//   record; raise pop to take it. One result per frame: its summary is written
//   into the queue, then registered into the output register once that is free.
//   A two-entry summary queue and the output register decouple the sides.
//   When the receiver stalls, summaries collect in the queue; once it and
//   the output register are occupied, full rises and bytes are held off.
//   Reset clears the byte offset, queue and output valid; the first byte
//   after reset starts a new frame.
//------------------------------------------------------------------------------
`default_nettype none

module ipv4_header_field_extractor (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       push,
	output logic                      full,
	input  ipv4hfe_pkg::in_item_t     frame_byte,
	output logic                      empty,
	input  wire                       pop,
	output ipv4hfe_pkg::out_item_t    result
);
	import ipv4hfe_pkg::*;

	logic          take;
	logic          sum_push;
	frame_sum_t    sum;
	frame_sum_t    head;
	queue_status_t q_status;
	logic          head_take;

	assign full = q_status.full;
	assign take = push && !q_status.full;

	ipv4hfe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (take),
		.frame_byte (frame_byte),
		.sum_push   (sum_push),
		.sum        (sum)
	);

	ipv4hfe_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (sum_push),
		.wr_data (sum),
		.rd      (head_take),
		.rd_data (head),
		.status  (q_status)
	);

	ipv4hfe_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (!q_status.empty),
		.head_take  (head_take),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

endmodule

`default_nettype wire
